/* sv/bloom_filter_engine_defines.svh */
// Assertion macros shared by the bloom filter engine RTL.
`ifndef BLOOM_FILTER_ENGINE_DEFINES_SVH
`define BLOOM_FILTER_ENGINE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bloom filter engine: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bloom filter engine: next-cycle check failed");

`endif

/* sv/bfe_pkg.sv */
// Package with constants, codes, types and helpers of the bloom filter engine.
`default_nettype none
package bfe_pkg;

    localparam int BITMAP_WORDS  = 1024;
    localparam int MAX_HASHES    = 8;
    localparam int MAX_KEY_BYTES = 4096;

    localparam int HASH_W   = 64;
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int NH_W     = 4;
    localparam int FB_W     = 17;
    localparam int COUNT_W  = 17;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 17;
    localparam int WORD_AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam int POS_W    = WORD_AW + 6;
    localparam int LANE_W   = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int LEN_W    = $clog2(MAX_KEY_BYTES + 1);
    localparam int FILTER_CAP = BITMAP_WORDS * 64;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 1'd1;

    localparam logic [NH_W-1:0] NH_RESET = 4'd4;
    localparam logic [FB_W-1:0] FB_RESET = 17'd65536;

    localparam logic [HASH_W-1:0] MM_C1   = 64'h87c37b91114253d5;
    localparam logic [HASH_W-1:0] MM_C2   = 64'h4cf5ad432745937f;
    localparam logic [HASH_W-1:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [HASH_W-1:0] MIX_H1  = 64'h0000000052dce729;
    localparam logic [HASH_W-1:0] MIX_H2  = 64'h0000000038495ab5;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE,
        S_K1A, S_K1B, S_K2A, S_K2B,
        S_LN_A, S_LN_B, S_LN_C, S_LN_D,
        S_FIN_A, S_FIN_B, S_FM1, S_FM2, S_FIN_C,
        S_MOD, S_RD, S_RMW, S_OUT
    } state_t;

    function automatic logic [HASH_W-1:0] rotl64(input logic [HASH_W-1:0] x,
                                                 input int unsigned r);
        return (x << r) | (x >> (HASH_W - r));
    endfunction

    function automatic logic [HASH_W-1:0] xsh33(input logic [HASH_W-1:0] x);
        return x ^ (x >> 33);
    endfunction

endpackage
`default_nettype wire

/* sv/bfe_ram.sv */
// Generic single-port RAM with registered read data.
`default_nettype none
module bfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  wire logic [WIDTH-1:0]                 wdata,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

/* sv/bfe_mul64.sv */
// Iterative 64 by 64 multiplier giving the low 64 bits, one 32 by 32 product a cycle.
`default_nettype none
module bfe_mul64 (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  go,
    input  wire logic [bfe_pkg::HASH_W-1:0] a,
    input  wire logic [bfe_pkg::HASH_W-1:0] b,
    output logic                       done,
    output logic      [bfe_pkg::HASH_W-1:0] result
);
    import bfe_pkg::*;

    localparam int HALF = HASH_W / 2;

    logic [1:0]        cnt_reg, cnt_next;
    logic [HASH_W-1:0] a_reg, b_reg, acc_reg;
    logic [HALF-1:0]   ma, mb;
    logic [HASH_W-1:0] prod;

    always_comb
    begin
        ma = a_reg[HALF-1:0];
        mb = b_reg[HALF-1:0];
        case (cnt_reg)
            2'd2:    mb = b_reg[HASH_W-1:HALF];
            2'd3:    ma = a_reg[HASH_W-1:HALF];
            default: ;
        endcase
        prod = HASH_W'(ma) * HASH_W'(mb);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cnt_reg == 2'd0)
        begin
            if (go)
            begin
                cnt_next = 2'd1;
            end
        end
        else
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    assign done   = (cnt_reg == 2'd3);
    assign result = acc_reg + {prod[HALF-1:0], {HALF{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == 2'd0 && go)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (cnt_reg == 2'd1)
        begin
            acc_reg <= prod;
        end
        else if (cnt_reg == 2'd2)
        begin
            acc_reg <= acc_reg + {prod[HALF-1:0], {HALF{1'b0}}};
        end
    end

endmodule
`default_nettype wire

/* sv/bfe_mod.sv */
// Bit-serial remainder unit: 64-bit hash modulo the filter size, one bit a cycle.
`default_nettype none
module bfe_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       go,
    input  wire logic [bfe_pkg::HASH_W-1:0] dividend,
    input  wire logic [bfe_pkg::FB_W-1:0]   divisor,
    output logic                            done,
    output logic      [bfe_pkg::FB_W-1:0]   remainder
);
    import bfe_pkg::*;

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] q_reg;
    logic [FB_W-1:0]   r_reg, d_reg;
    logic [FB_W:0]     r_shift, r_sub;
    logic [FB_W-1:0]   r_step;

    always_comb
    begin
        r_shift = {r_reg, q_reg[HASH_W-1]};
        r_sub   = r_shift - {1'b0, d_reg};
        r_step  = (r_shift >= {1'b0, d_reg}) ? r_sub[FB_W-1:0] : r_shift[FB_W-1:0];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cnt_reg == '0)
        begin
            if (go)
            begin
                cnt_next = CNT_W'(1);
            end
        end
        else if (cnt_reg == CNT_W'(HASH_W))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    assign done      = (cnt_reg == CNT_W'(HASH_W));
    assign remainder = r_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg == '0)
        begin
            if (go)
            begin
                q_reg <= dividend;
                r_reg <= '0;
                d_reg <= divisor;
            end
        end
        else
        begin
            q_reg <= {q_reg[HASH_W-2:0], 1'b0};
            r_reg <= r_step;
        end
    end

endmodule
`default_nettype wire

/* sv/bloom_filter_engine.sv */
// Top level of the bloom filter engine: sequencer, hash lanes and bitmap.
// A beat is taken when start is high and busy is low; a key byte that does not close a
// 16-byte block and is not last leaves busy low. A byte that closes a block keeps busy high
// while one shared multiplier folds the block into all eight hash lanes. The beat with
// last set runs the command: add or test runs, for each hash lane in use, the multiplier
// (four products per lane) and the bit-serial modulo, then a read-modify-write of one
// bitmap word. Clear sweeps the 1024-word bitmap; the same sweep runs after reset with
// busy high. The result is on present and set_count for exactly one cycle with done
// high; the receiver cannot stall it. The user must write configuration only while busy
// is low; the block itself does not enforce this.
`default_nettype none
`include "bloom_filter_engine_defines.svh"
module bloom_filter_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [bfe_pkg::CMD_W-1:0]     cmd,
    input  wire logic [bfe_pkg::BYTE_W-1:0]    key_byte,
    input  wire logic                          byte_valid,
    input  wire logic                          last,
    output logic                               done,
    output logic                               present,
    output logic      [bfe_pkg::COUNT_W-1:0]   set_count,
    input  wire logic                          cfg_write,
    input  wire logic [bfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfe_pkg::CFG_W-1:0]     cfg_data
);
    import bfe_pkg::*;

    state_t state_reg, state_next;

    logic [NH_W-1:0]    nh_reg;
    logic [FB_W-1:0]    fb_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LANE_W-1:0]  lane_reg;
    logic [WORD_AW-1:0] clr_reg;
    logic               init_reg;
    logic               fin_reg;
    logic               last_reg;
    logic               all_reg;
    logic               fsel_reg;
    logic [CMD_W-1:0]   cmd_reg;

    logic [BYTE_W-1:0]  blk_reg [16];
    logic [HASH_W-1:0]  lane_lo_reg [MAX_HASHES];
    logic [HASH_W-1:0]  lane_hi_reg [MAX_HASHES];
    logic [HASH_W-1:0]  k1_reg, k2_reg, t_reg, w1_reg, w2_reg;
    logic [POS_W-1:0]   pos_reg;

    logic               take;
    logic               byte_take;
    logic [LEN_W-1:0]   len_inc;
    logic               block_full;
    logic [CMD_W-1:0]   end_cmd;
    state_t             end_state;
    logic [NH_W-1:0]    n_eff;
    logic [FB_W-1:0]    mod_eff;
    logic [4:0]         vcount;
    logic [HASH_W-1:0]  load_lo, load_hi;
    logic               seed;
    logic [HASH_W-1:0]  hl, hh, fx, len64;
    logic               lane_end;
    logic               bit_set;

    logic               mul_go, mul_done;
    logic [HASH_W-1:0]  mul_a, mul_b, mul_res;
    logic               mod_go, mod_done;
    logic [FB_W-1:0]    mod_rem;
    logic               ram_we;
    logic [WORD_AW-1:0] ram_addr;
    logic [HASH_W-1:0]  ram_wdata, ram_rdata;

    bfe_mul64 u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mul_go),
        .a      (mul_a),
        .b      (mul_b),
        .done   (mul_done),
        .result (mul_res)
    );

    bfe_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (mod_go),
        .dividend  (w1_reg),
        .divisor   (mod_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    bfe_ram #(
        .WIDTH (HASH_W),
        .DEPTH (BITMAP_WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        take       = start && (state_reg == S_IDLE);
        byte_take  = take && byte_valid && (len_reg < LEN_W'(MAX_KEY_BYTES));
        len_inc    = len_reg + LEN_W'(1);
        block_full = byte_take && (len_inc[3:0] == 4'd0);
        end_cmd    = (state_reg == S_IDLE) ? cmd : cmd_reg;
        if (end_cmd == CMD_CLEAR)
        begin
            end_state = S_CLR;
        end
        else if (end_cmd == CMD_ADD || end_cmd == CMD_TEST)
        begin
            end_state = S_K1A;
        end
        else
        begin
            end_state = S_OUT;
        end

        if (nh_reg == '0)
        begin
            n_eff = NH_W'(1);
        end
        else if (nh_reg > NH_W'(MAX_HASHES))
        begin
            n_eff = NH_W'(MAX_HASHES);
        end
        else
        begin
            n_eff = nh_reg;
        end

        if (fb_reg == '0)
        begin
            mod_eff = FB_W'(1);
        end
        else if (fb_reg > FB_W'(FILTER_CAP))
        begin
            mod_eff = FB_W'(FILTER_CAP);
        end
        else
        begin
            mod_eff = fb_reg;
        end

        vcount = fin_reg ? {1'b0, len_reg[3:0]} : 5'd16;
        for (int i = 0; i < 8; i++)
        begin
            load_lo[8*i +: 8] = (5'(i) < vcount) ? blk_reg[i] : 8'd0;
            load_hi[8*i +: 8] = (5'(i + 8) < vcount) ? blk_reg[i + 8] : 8'd0;
        end

        seed  = fin_reg ? (len_reg < LEN_W'(16)) : (len_reg == LEN_W'(16));
        hl    = seed ? HASH_W'(lane_reg) : lane_lo_reg[lane_reg];
        hh    = seed ? HASH_W'(lane_reg) : lane_hi_reg[lane_reg];
        fx    = fsel_reg ? w2_reg : w1_reg;
        len64 = HASH_W'(len_reg);
        bit_set = ram_rdata[pos_reg[5:0]];
        if (fin_reg)
        begin
            lane_end = (NH_W'(lane_reg) == n_eff - NH_W'(1));
        end
        else
        begin
            lane_end = (lane_reg == LANE_W'(MAX_HASHES - 1));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mul_go     = 1'b0;
        mul_a      = load_lo;
        mul_b      = MM_C1;
        mod_go     = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = pos_reg[POS_W-1:6];
        ram_wdata  = ram_rdata | (HASH_W'(1) << pos_reg[5:0]);
        unique case (state_reg)
            S_CLR:
            begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = '0;
                if (clr_reg == WORD_AW'(BITMAP_WORDS - 1))
                begin
                    state_next = init_reg ? S_IDLE : S_OUT;
                end
            end
            S_IDLE:
            begin
                if (take)
                begin
                    if (block_full)
                    begin
                        state_next = S_K1A;
                    end
                    else if (last)
                    begin
                        state_next = end_state;
                    end
                end
            end
            S_K1A:
            begin
                mul_go = 1'b1;
                if (mul_done)
                begin
                    state_next = S_K1B;
                end
            end
            S_K1B:
            begin
                mul_go = 1'b1;
                mul_a  = rotl64(t_reg, 31);
                mul_b  = MM_C2;
                if (mul_done)
                begin
                    state_next = S_K2A;
                end
            end
            S_K2A:
            begin
                mul_go = 1'b1;
                mul_a  = load_hi;
                mul_b  = MM_C2;
                if (mul_done)
                begin
                    state_next = S_K2B;
                end
            end
            S_K2B:
            begin
                mul_go = 1'b1;
                mul_a  = rotl64(t_reg, 33);
                mul_b  = MM_C1;
                if (mul_done)
                begin
                    state_next = fin_reg ? S_FIN_A : S_LN_A;
                end
            end
            S_LN_A: state_next = S_LN_B;
            S_LN_B: state_next = S_LN_C;
            S_LN_C: state_next = S_LN_D;
            S_LN_D:
            begin
                if (!lane_end)
                begin
                    state_next = S_LN_A;
                end
                else if (last_reg)
                begin
                    state_next = end_state;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FIN_A: state_next = S_FIN_B;
            S_FIN_B: state_next = S_FM1;
            S_FM1:
            begin
                mul_go = 1'b1;
                mul_a  = xsh33(fx);
                mul_b  = FMIX_C1;
                if (mul_done)
                begin
                    state_next = S_FM2;
                end
            end
            S_FM2:
            begin
                mul_go = 1'b1;
                mul_a  = xsh33(fx);
                mul_b  = FMIX_C2;
                if (mul_done)
                begin
                    state_next = fsel_reg ? S_FIN_C : S_FM1;
                end
            end
            S_FIN_C: state_next = S_MOD;
            S_MOD:
            begin
                mod_go = 1'b1;
                if (mod_done)
                begin
                    state_next = S_RD;
                end
            end
            S_RD: state_next = S_RMW;
            S_RMW:
            begin
                ram_we = (cmd_reg == CMD_ADD) && !bit_set;
                state_next = lane_end ? S_OUT : S_FIN_A;
            end
            S_OUT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            init_reg  <= 1'b1;
            clr_reg   <= '0;
            nh_reg    <= NH_RESET;
            fb_reg    <= FB_RESET;
            len_reg   <= '0;
            count_reg <= '0;
            lane_reg  <= '0;
            fin_reg   <= 1'b0;
            last_reg  <= 1'b0;
            fsel_reg  <= 1'b0;
            all_reg   <= 1'b0;
            cmd_reg   <= CMD_ADD;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_NUM_HASHES:  nh_reg <= cfg_data[NH_W-1:0];
                    CFG_FILTER_BITS: fb_reg <= cfg_data[FB_W-1:0];
                    default: ;
                endcase
            end
            if (take)
            begin
                cmd_reg  <= cmd;
                last_reg <= last;
                if (byte_take)
                begin
                    len_reg <= len_inc;
                end
            end
            if (state_next == S_K1A && state_reg != S_K1A)
            begin
                lane_reg <= '0;
                fin_reg  <= !block_full || (state_reg != S_IDLE);
                all_reg  <= 1'b1;
            end
            if (state_next == S_CLR && state_reg != S_CLR)
            begin
                init_reg <= 1'b0;
                clr_reg  <= '0;
            end
            else if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + WORD_AW'(1);
                if (!init_reg && state_next == S_OUT)
                begin
                    count_reg <= '0;
                end
                if (state_next == S_IDLE)
                begin
                    init_reg <= 1'b0;
                end
            end
            if ((state_reg == S_LN_D || state_reg == S_RMW) && !lane_end)
            begin
                lane_reg <= lane_reg + LANE_W'(1);
            end
            if (state_reg == S_FIN_B)
            begin
                fsel_reg <= 1'b0;
            end
            if (state_reg == S_FM2 && mul_done)
            begin
                fsel_reg <= 1'b1;
            end
            if (state_reg == S_RMW && !bit_set)
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
                else
                begin
                    all_reg <= 1'b0;
                end
            end
            if (state_reg == S_OUT)
            begin
                len_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            blk_reg[len_reg[3:0]] <= key_byte;
        end
        case (state_reg)
            S_K1A:   if (mul_done) t_reg <= mul_res;
            S_K1B:   if (mul_done) k1_reg <= mul_res;
            S_K2A:   if (mul_done) t_reg <= mul_res;
            S_K2B:   if (mul_done) k2_reg <= mul_res;
            S_LN_A:  t_reg <= rotl64(hl ^ k1_reg, 27) + hh;
            S_LN_B:  w1_reg <= (t_reg << 2) + t_reg + MIX_H1;
            S_LN_C:  t_reg <= rotl64(hh ^ k2_reg, 31) + w1_reg;
            S_LN_D:
            begin
                lane_lo_reg[lane_reg] <= w1_reg;
                lane_hi_reg[lane_reg] <= (t_reg << 2) + t_reg + MIX_H2;
            end
            S_FIN_A:
            begin
                w1_reg <= (hl ^ k1_reg ^ len64) + (hh ^ k2_reg ^ len64);
                w2_reg <= hh ^ k2_reg ^ len64;
            end
            S_FIN_B: w2_reg <= w2_reg + w1_reg;
            S_FM1:
            begin
                if (mul_done)
                begin
                    if (fsel_reg) w2_reg <= mul_res;
                    else          w1_reg <= mul_res;
                end
            end
            S_FM2:
            begin
                if (mul_done)
                begin
                    if (fsel_reg) w2_reg <= xsh33(mul_res);
                    else          w1_reg <= xsh33(mul_res);
                end
            end
            S_FIN_C: w1_reg <= w1_reg + w2_reg;
            S_MOD:   if (mod_done) pos_reg <= mod_rem[POS_W-1:0];
            default: ;
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_OUT);
    assign present   = done && (cmd_reg == CMD_TEST) && all_reg;
    assign set_count = count_reg;

    // A result beat lasts one cycle and is never repeated back to back.
    `BFE_ASSERT_NEXT(a_done_single, done, !done)
    // Only a test can report a key as present.
    `BFE_ASSERT_SAME(a_present_test, done && present, cmd_reg == CMD_TEST)
    // A clear always reports an empty bitmap.
    `BFE_ASSERT_SAME(a_clear_zero, done && cmd_reg == CMD_CLEAR, set_count == '0)
    // No new beat is taken while the modulo of a key end is running.
    `BFE_ASSERT_SAME(a_no_take_busy, state_reg == S_MOD, busy && !take)

endmodule
`default_nettype wire

/* dv/tb_bloom_filter_engine.sv */
// Testbench for the bloom filter engine: queued driver, result monitor and hash predictor.
`default_nettype none
module tb_bloom_filter_engine;
    timeunit 1ns;
    timeprecision 1ps;
    import bfe_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 60000;

    typedef enum int { K_BEAT, K_CFG, K_DRAIN, K_MODE } kind_t;

    typedef struct {
        kind_t             kind;
        logic [CMD_W-1:0]  cmd;
        logic [7:0]        kbyte;
        logic              valid;
        logic              last;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]  data;
        int                pct;
    } item_t;

    typedef struct {
        logic               present;
        logic [COUNT_W-1:0] count;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [CMD_W-1:0] cmd = '0;
    logic [7:0] key_byte = '0;
    logic byte_valid = 1'b0;
    logic last = 1'b0;
    logic done;
    logic present;
    logic [COUNT_W-1:0] set_count;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    bloom_filter_engine u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .key_byte(key_byte), .byte_valid(byte_valid), .last(last),
        .done(done), .present(present), .set_count(set_count),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    item_t   pending_items[$];
    lookup_t expected_lookups[$];
    int      mismatches = 0;
    int      quiet = 0;
    int      idle_cycles = 0;
    int      send_pct = 0;

    // Predictor state.
    logic [63:0] pbitmap [BITMAP_WORDS];
    logic [63:0] plow [MAX_HASHES];
    logic [63:0] phigh [MAX_HASHES];
    logic [7:0]  pblock [16];
    int          plen = 0;
    logic [COUNT_W-1:0] pcount = '0;
    logic [NH_W-1:0] pnh = NH_RESET;
    logic [FB_W-1:0] pfb = FB_RESET;

    function automatic logic [63:0] rot(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] mix_final(input logic [63:0] k);
        logic [63:0] v;
        v = k ^ (k >> 33);
        v = v * 64'hff51afd7ed558ccd;
        v = v ^ (v >> 33);
        v = v * 64'hc4ceb9fe1a85ec53;
        return v ^ (v >> 33);
    endfunction

    function automatic logic [63:0] block_word(input int from, input int count);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < count; i++)
            v |= 64'(pblock[(from + i) & 15]) << (8 * i);
        return v;
    endfunction

    function automatic void seed_lanes();
        for (int s = 0; s < MAX_HASHES; s++)
        begin
            plow[s] = 64'(s);
            phigh[s] = 64'(s);
        end
    endfunction

    function automatic void fold_lanes();
        logic [63:0] a, b, h1, h2, k1, k2;
        a = block_word(0, 8);
        b = block_word(8, 8);
        for (int s = 0; s < MAX_HASHES; s++)
        begin
            h1 = plow[s];
            h2 = phigh[s];
            k1 = rot(a * 64'h87c37b91114253d5, 31) * 64'h4cf5ad432745937f;
            h1 = h1 ^ k1;
            h1 = (rot(h1, 27) + h2) * 64'd5 + 64'h52dce729;
            k2 = rot(b * 64'h4cf5ad432745937f, 33) * 64'h87c37b91114253d5;
            h2 = h2 ^ k2;
            h2 = (rot(h2, 31) + h1) * 64'd5 + 64'h38495ab5;
            plow[s] = h1;
            phigh[s] = h2;
        end
    endfunction

    function automatic logic [63:0] lane_hash(input int s, input int tail);
        logic [63:0] h1, h2, k, len;
        h1 = plow[s];
        h2 = phigh[s];
        len = 64'(plen);
        if (tail > 8)
        begin
            k = rot(block_word(8, tail - 8) * 64'h4cf5ad432745937f, 33) * 64'h87c37b91114253d5;
            h2 = h2 ^ k;
        end
        if (tail > 0)
        begin
            k = block_word(0, (tail > 8) ? 8 : tail);
            k = rot(k * 64'h87c37b91114253d5, 31) * 64'h4cf5ad432745937f;
            h1 = h1 ^ k;
        end
        h1 = h1 ^ len;
        h2 = h2 ^ len;
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = mix_final(h1);
        h2 = mix_final(h2);
        return h1 + h2;
    endfunction

    function automatic void forget_key();
        for (int s = 0; s < MAX_HASHES; s++)
        begin
            plow[s] = '0;
            phigh[s] = '0;
        end
        for (int i = 0; i < 16; i++)
            pblock[i] = '0;
        plen = 0;
    endfunction

    function automatic void predict_beat(input logic [CMD_W-1:0] c, input logic [7:0] b,
                                         input logic v, input logic l);
        int n, tail;
        logic [63:0] modulus, pos, mask;
        logic all_set;
        lookup_t r;
        if (v && plen < MAX_KEY_BYTES)
        begin
            pblock[plen & 15] = b;
            plen++;
            if ((plen & 15) == 0)
            begin
                if (plen == 16)
                    seed_lanes();
                fold_lanes();
            end
        end
        if (!l)
            return;
        all_set = 1'b1;
        if (c == CMD_CLEAR)
        begin
            for (int w = 0; w < BITMAP_WORDS; w++)
                pbitmap[w] = '0;
            pcount = '0;
        end
        else if (c == CMD_ADD || c == CMD_TEST)
        begin
            tail = plen & 15;
            n = int'(pnh);
            if (n < 1) n = 1;
            if (n > MAX_HASHES) n = MAX_HASHES;
            modulus = 64'(pfb);
            if (modulus == 0) modulus = 1;
            if (modulus > FILTER_CAP) modulus = FILTER_CAP;
            if (plen < 16)
                seed_lanes();
            for (int s = 0; s < n; s++)
            begin
                pos = lane_hash(s, tail) % modulus;
                mask = 64'h1 << pos[5:0];
                if ((pbitmap[pos >> 6] & mask) == 0)
                begin
                    if (c == CMD_ADD)
                    begin
                        pbitmap[pos >> 6] |= mask;
                        pcount++;
                    end
                    else
                        all_set = 1'b0;
                end
            end
        end
        forget_key();
        r.present = (c == CMD_TEST) && all_set;
        r.count = pcount;
        expected_lookups.push_back(r);
    endfunction

    // Driver.
    always @(posedge clk or negedge rst_n)
    begin
        logic next_start;
        logic next_cfg;
        int next_quiet;
        item_t it;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_write <= 1'b0;
            quiet <= 0;
        end
        else
        begin
            next_start = start;
            next_cfg = 1'b0;
            next_quiet = quiet + 1;
            if (start && !busy)
            begin
                predict_beat(cmd, key_byte, byte_valid, last);
                next_start = 1'b0;
                next_quiet = 0;
            end
            if (!next_start && pending_items.size() > 0)
            begin
                it = pending_items[0];
                case (it.kind)
                    K_MODE:
                    begin
                        send_pct = it.pct;
                        void'(pending_items.pop_front());
                    end
                    K_DRAIN, K_CFG:
                    begin
                        if (expected_lookups.size() == 0 && quiet >= QUIET_CYCLES && !busy
                            && !start)
                        begin
                            if (it.kind == K_CFG)
                            begin
                                next_cfg = 1'b1;
                                cfg_index <= it.idx;
                                cfg_data <= it.data;
                                if (it.idx == CFG_NUM_HASHES)
                                    pnh = it.data[NH_W-1:0];
                                else
                                    pfb = it.data[FB_W-1:0];
                            end
                            void'(pending_items.pop_front());
                        end
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= send_pct)
                        begin
                            cmd <= it.cmd;
                            key_byte <= it.kbyte;
                            byte_valid <= it.valid;
                            last <= it.last;
                            next_start = 1'b1;
                            void'(pending_items.pop_front());
                        end
                    end
                endcase
            end
            start <= next_start;
            cfg_write <= next_cfg;
            quiet <= next_quiet;
        end
    end

    // Monitor.
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done)
        begin
            if (expected_lookups.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: present %0d set_count %0d", present, set_count);
            end
            else
            begin
                e = expected_lookups.pop_front();
                if (e.present !== present || e.count !== set_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected present %0d set_count %0d, got %0d %0d",
                                 e.present, e.count, present, set_count);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    logic [7:0] pool_b [32][40];
    int pool_n [32];
    int beats = 0;

    task automatic push_beat(input logic [CMD_W-1:0] c, input logic [7:0] b,
                             input logic v, input logic l);
        item_t it;
        it = '{kind: K_BEAT, cmd: c, kbyte: b, valid: v, last: l, idx: '0, data: '0, pct: 0};
        pending_items.push_back(it);
        beats++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] i, input logic [CFG_W-1:0] d);
        item_t it;
        it = '{kind: K_CFG, cmd: '0, kbyte: '0, valid: 0, last: 0, idx: i, data: d, pct: 0};
        pending_items.push_back(it);
    endtask

    task automatic push_ctl(input kind_t k, input int p);
        item_t it;
        it = '{kind: k, cmd: '0, kbyte: '0, valid: 0, last: 0, idx: '0, data: '0, pct: p};
        pending_items.push_back(it);
    endtask

    // A key from the pool, with optional gaps of invalid beats and a closing empty beat.
    task automatic push_key(input int id, input logic [CMD_W-1:0] c, input bit noisy);
        int n;
        bit close_empty;
        n = pool_n[id];
        close_empty = (n == 0) || (noisy && $urandom_range(3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (noisy && $urandom_range(5) == 0)
                push_beat(2'($urandom_range(3)), 8'($urandom), 1'b0, 1'b0);
            push_beat((i == n - 1 && !close_empty) ? c : 2'($urandom_range(3)),
                      pool_b[id][i], 1'b1, (i == n - 1) && !close_empty);
        end
        if (close_empty)
            push_beat(c, 8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_keys(input int count);
        int r;
        logic [CMD_W-1:0] c;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            if (r < 45) c = CMD_ADD;
            else if (r < 90) c = CMD_TEST;
            else if (r < 95) c = CMD_CLEAR;
            else c = CMD_UNUSED;
            if ($urandom_range(9) == 0)
                for (int i = 0; i < 40; i++)
                    pool_b[$urandom_range(31)][i] = 8'($urandom);
            push_key($urandom_range(31), c, $urandom_range(4) == 0);
        end
    endtask

    initial
    begin
        for (int w = 0; w < BITMAP_WORDS; w++)
            pbitmap[w] = '0;
        forget_key();
        for (int id = 0; id < 32; id++)
        begin
            pool_n[id] = (id < 24) ? id : 16 + $urandom_range(24);
            for (int i = 0; i < 40; i++)
                pool_b[id][i] = 8'($urandom);
        end
        pool_b[1][0] = 8'h00;
        pool_b[2][0] = 8'hff;
        pool_b[2][1] = 8'hff;

        push_ctl(K_MODE, 12);
        push_key(0, CMD_ADD, 0);
        push_key(0, CMD_TEST, 0);
        push_key(1, CMD_TEST, 0);
        push_key(2, CMD_ADD, 0);
        push_key(16, CMD_ADD, 0);
        push_key(16, CMD_TEST, 0);
        push_key(17, CMD_UNUSED, 0);
        push_key(17, CMD_TEST, 1);
        push_key(3, CMD_CLEAR, 0);
        push_key(16, CMD_TEST, 0);
        push_ctl(K_DRAIN, 0);
        push_cfg(CFG_NUM_HASHES, 17'd8);
        push_cfg(CFG_FILTER_BITS, 17'd64);
        random_keys(10);
        push_ctl(K_DRAIN, 0);
        push_cfg(CFG_NUM_HASHES, 17'd1);
        push_cfg(CFG_FILTER_BITS, 17'd1000);
        random_keys(15);
        push_ctl(K_DRAIN, 0);

        push_ctl(K_MODE, 73);
        push_cfg(CFG_NUM_HASHES, 17'd0);
        push_cfg(CFG_FILTER_BITS, 17'd0);
        random_keys(5);
        push_ctl(K_DRAIN, 0);
        push_cfg(CFG_NUM_HASHES, 17'h1ffff);
        push_cfg(CFG_FILTER_BITS, 17'h1ffff);
        random_keys(12);
        // An overlong key: bytes beyond the limit are dropped.
        for (int i = 0; i < MAX_KEY_BYTES + 8; i++)
            push_beat(CMD_ADD, 8'($urandom), 1'b1, i == MAX_KEY_BYTES + 7);
        push_beat(CMD_TEST, 8'h00, 1'b0, 1'b1);
        push_ctl(K_DRAIN, 0);

        push_ctl(K_MODE, 0);
        push_cfg(CFG_NUM_HASHES, 17'd5);
        push_cfg(CFG_FILTER_BITS, 17'd300);
        random_keys(15);
        push_ctl(K_DRAIN, 0);
        push_cfg(CFG_NUM_HASHES, 17'd3);
        push_cfg(CFG_FILTER_BITS, 17'd65536);
        while (beats < MAX_KEY_BYTES + 1500)
            random_keys(10);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge clk);
        while (start || expected_lookups.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_lookups.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

/* bloom_filter_engine.f */
+incdir+sv
sv/bfe_pkg.sv
sv/bfe_ram.sv
sv/bfe_mul64.sv
sv/bfe_mod.sv
sv/bloom_filter_engine.sv
dv/tb_bloom_filter_engine.sv
